/* src/edh_pkg.sv */
// Shared types, constants and arithmetic helpers for the halftone block.
`timescale 1ns / 1ps

package edh_pkg;

   localparam int ERR_W       = 12;
   localparam int PIXEL_W     = 8;
   localparam int WIDTH_REG_W = 11;
   localparam int ROW_W       = 16;
   localparam int CSR_DATA_W  = 16;

   typedef logic signed [ERR_W-1:0] err_type;
   typedef logic signed [ERR_W:0]   err_sum_type;
   typedef logic [PIXEL_W-1:0]      pixel_type;
   typedef logic [ROW_W-1:0]        row_type;

   localparam err_type ERR_MAX = 12'h7FF;
   localparam err_type ERR_MIN = 12'h800;

   localparam int THRESHOLD   = 128;
   localparam int WHITE_LEVEL = 255;
   localparam pixel_type PIXEL_WHITE = 8'd255;
   localparam pixel_type PIXEL_BLACK = 8'd0;

   localparam logic [2:0] W_RIGHT      = 3'd7;
   localparam logic [2:0] W_DOWN_LEFT  = 3'd3;
   localparam logic [2:0] W_DOWN       = 3'd5;
   localparam logic [2:0] W_DOWN_RIGHT = 3'd1;
   localparam int SHARE_SHIFT = 4;

   localparam int RESET_WIDTH  = 1024;
   localparam int RESET_HEIGHT = 1024;

   localparam int RSP_DEPTH = 3;
   typedef logic [1:0] rsp_ptr_type;
   typedef logic [1:0] rsp_count_type;

   typedef struct packed {
      pixel_type out_pixel;
      logic      end_of_row;
      logic      end_of_frame;
   } rsp_type;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   function automatic err_type sat_err(input err_sum_type v);
      if (v > err_sum_type'(ERR_MAX)) begin
         return ERR_MAX;
      end else if (v < err_sum_type'(ERR_MIN)) begin
         return ERR_MIN;
      end
      return err_type'(v);
   endfunction

   // d * k / 16, truncated toward zero
   function automatic err_type err_share(input err_type d, input logic [2:0] k);
      logic signed [15:0] p;
      p = $signed({{4{d[ERR_W-1]}}, d}) * $signed({13'd0, k});
      if (p < 0) begin
         p = p + 16'sd15;
      end
      return err_type'(p >>> SHARE_SHIFT);
   endfunction

endpackage

/* src/error_diffusion_halftone.sv */
// Floyd-Steinberg halftoning of a raster-order 8-bit grayscale request stream.
// Requests pass a registered diffusion stage, then the output queue. One request
// per cycle is taken while that queue has room; the pixel-to-pixel error loop
// in that stage (read, threshold, weighted shares) sets the clock period.
// Reset: synchronous; width and height return to 1024, position and error clear.
// The error row needs no clearing pass: row 0 of each frame reads it as zero.
`timescale 1ns / 1ps

module error_diffusion_halftone #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [edh_pkg::PIXEL_W-1:0]       req_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [edh_pkg::PIXEL_W-1:0]       rsp_out_pixel,
   output logic                              rsp_end_of_row,
   output logic                              rsp_end_of_frame,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [edh_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import edh_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   typedef logic [AW-1:0] col_type;

   function automatic col_type last_col_of(input logic [WIDTH_REG_W-1:0] v);
      if (v == '0) begin
         return '0;
      end else if (32'(v) > 32'(MAX_WIDTH)) begin
         return col_type'(MAX_WIDTH - 1);
      end
      return col_type'(32'(v) - 32'd1);
   endfunction

   function automatic row_type last_row_of(input row_type v);
      return (v == '0) ? '0 : v - 16'd1;
   endfunction

   // configuration
   col_type lastcol_ff, lastcol_in;
   row_type lastrow_ff, lastrow_in;

   // request side
   logic    accept;
   col_type iss_col_ff, iss_col_in;
   logic    s1_valid_ff, s1_valid_in;
   pixel_type s1_pixel_ff;

   // diffusion state
   col_type col_ff, col_in;
   row_type row_ff, row_in;
   err_type right_err_ff, right_err_in;
   err_type bp0_ff, bp0_in;
   err_type bp1_ff, bp1_in;

   // error row memory and write tracking
   err_type err_mem [MAX_WIDTH];
   err_type rd_data_ff;
   logic    pend_valid_ff, pend_valid_in;
   col_type pend_addr_ff, pend_addr_in;
   err_type pend_data_ff, pend_data_in;
   logic    lw_valid_ff, lw_valid_in;
   col_type lw_addr_ff;
   err_type lw_data_ff;
   logic    wr_en;
   col_type wr_addr;
   err_type wr_data;
   logic    norm_wr_en;

   // datapath
   logic        last_col, last_row;
   err_type     fwd_err, cell_err, acc_err, diff;
   err_sum_type level;
   logic        is_white;
   err_type     below_left, below_new;

   // output queue
   logic          push, pop;
   rsp_type       push_data, out_data;
   rsp_count_type fifo_count;
   logic [2:0]    inflight;

   assign inflight  = {1'b0, fifo_count} + {2'b00, s1_valid_ff};
   assign req_ready = (inflight < 3'(RSP_DEPTH));
   assign accept    = req_valid && req_ready;

   assign last_col = (col_ff == lastcol_ff);
   assign last_row = (row_ff >= lastrow_ff);

   always_comb begin
      if (pend_valid_ff && (pend_addr_ff == col_ff)) begin
         fwd_err = pend_data_ff;
      end else if (lw_valid_ff && (lw_addr_ff == col_ff)) begin
         fwd_err = lw_data_ff;
      end else begin
         fwd_err = rd_data_ff;
      end
   end

   assign cell_err = (row_ff == '0) ? '0 : fwd_err;
   assign acc_err  = sat_err(err_sum_type'(cell_err) + err_sum_type'(right_err_ff));
   assign level    = $signed({5'd0, s1_pixel_ff}) + err_sum_type'(acc_err);
   assign is_white = (level >= err_sum_type'(THRESHOLD));
   assign diff     = is_white ? err_type'(level - err_sum_type'(WHITE_LEVEL))
                              : err_type'(level);

   assign below_left = sat_err(err_sum_type'(bp0_ff)
                               + err_sum_type'(err_share(diff, W_DOWN_LEFT)));
   assign below_new  = sat_err(err_sum_type'(bp1_ff)
                               + err_sum_type'(err_share(diff, W_DOWN)));

   assign norm_wr_en = s1_valid_ff && !last_row && (col_ff != '0);
   assign wr_en      = pend_valid_ff || norm_wr_en;
   assign wr_addr    = pend_valid_ff ? pend_addr_ff : col_ff - col_type'(1);
   assign wr_data    = pend_valid_ff ? pend_data_ff : below_left;

   always_comb begin
      lastcol_in    = lastcol_ff;
      lastrow_in    = lastrow_ff;
      iss_col_in    = iss_col_ff;
      s1_valid_in   = accept;
      col_in        = col_ff;
      row_in        = row_ff;
      right_err_in  = right_err_ff;
      bp0_in        = bp0_ff;
      bp1_in        = bp1_ff;
      pend_valid_in = 1'b0;
      pend_addr_in  = col_ff;
      pend_data_in  = below_new;
      lw_valid_in   = wr_en;

      if (accept) begin
         iss_col_in = (iss_col_ff == lastcol_ff) ? '0 : iss_col_ff + col_type'(1);
      end

      if (s1_valid_ff) begin
         right_err_in = last_col ? '0 : err_share(diff, W_RIGHT);
         if (!last_row) begin
            bp0_in = below_new;
            bp1_in = last_col ? '0 : err_share(diff, W_DOWN_RIGHT);
         end
         if (last_col) begin
            col_in = '0;
            bp0_in = '0;
            bp1_in = '0;
            if (last_row) begin
               row_in = '0;
            end else begin
               row_in        = row_ff + 16'd1;
               pend_valid_in = 1'b1;
            end
         end else begin
            col_in = col_ff + col_type'(1);
         end
      end

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               lastcol_in = last_col_of(csr_wdata[WIDTH_REG_W-1:0]);
            end
            CSR_IMAGE_HEIGHT: begin
               lastrow_in = last_row_of(csr_wdata[ROW_W-1:0]);
            end
         endcase
         iss_col_in    = '0;
         col_in        = '0;
         row_in        = '0;
         right_err_in  = '0;
         bp0_in        = '0;
         bp1_in        = '0;
         pend_valid_in = 1'b0;
         lw_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lastcol_ff    <= last_col_of(WIDTH_REG_W'(RESET_WIDTH));
         lastrow_ff    <= last_row_of(row_type'(RESET_HEIGHT));
         iss_col_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         right_err_ff  <= '0;
         bp0_ff        <= '0;
         bp1_ff        <= '0;
         pend_valid_ff <= 1'b0;
         lw_valid_ff   <= 1'b0;
      end else begin
         lastcol_ff    <= lastcol_in;
         lastrow_ff    <= lastrow_in;
         iss_col_ff    <= iss_col_in;
         s1_valid_ff   <= s1_valid_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         right_err_ff  <= right_err_in;
         bp0_ff        <= bp0_in;
         bp1_ff        <= bp1_in;
         pend_valid_ff <= pend_valid_in;
         lw_valid_ff   <= lw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
      end
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      lw_addr_ff   <= wr_addr;
      lw_data_ff   <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         err_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= err_mem[iss_col_ff];
   end

   assign push                   = s1_valid_ff;
   assign push_data.out_pixel    = is_white ? PIXEL_WHITE : PIXEL_BLACK;
   assign push_data.end_of_row   = last_col;
   assign push_data.end_of_frame = last_col && last_row;
   assign pop                    = rsp_valid && rsp_ready;

   edh_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .count     (fifo_count)
   );

   assign rsp_out_pixel    = out_data.out_pixel;
   assign rsp_end_of_row   = out_data.end_of_row;
   assign rsp_end_of_frame = out_data.end_of_frame;

`ifndef SYNTHESIS
   a_write_port_free: assert property (@(posedge clock) disable iff (reset)
      !(pend_valid_ff && norm_wr_en))
      else $error("row write and deferred write collide");

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (fifo_count == rsp_count_type'(RSP_DEPTH))))
      else $error("result queue overflow");

   a_issue_matches_stage: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !$past(csr_we)) |-> (col_ff == $past(iss_col_ff)))
      else $error("read column and processed column differ");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= lastcol_ff) && (iss_col_ff <= lastcol_ff))
      else $error("column beyond row end");

   a_frame_ends_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_end_of_frame || rsp_end_of_row))
      else $error("frame end without row end");
`endif

endmodule

/* src/edh_out_fifo.sv */
// Three-entry result queue between the error stage and the response port.
`timescale 1ns / 1ps

module edh_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  edh_pkg::rsp_type       push_data,
   input  logic                   pop,
   output logic                   out_valid,
   output edh_pkg::rsp_type       out_data,
   output edh_pkg::rsp_count_type count
);
   import edh_pkg::*;

   localparam rsp_ptr_type PTR_LAST = rsp_ptr_type'(RSP_DEPTH - 1);

   rsp_type       entry_ff [RSP_DEPTH];
   rsp_ptr_type   wr_ptr_ff, wr_ptr_in;
   rsp_ptr_type   rd_ptr_ff, rd_ptr_in;
   rsp_count_type count_ff, count_in;

   function automatic rsp_ptr_type next_ptr(input rsp_ptr_type p);
      return (p == PTR_LAST) ? '0 : p + 2'd1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + rsp_count_type'(push) - rsp_count_type'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

/* verif/tb_error_diffusion_halftone.sv */
// Testbench for the halftone block: gapped pixel stream checked against a built-in predictor.
`timescale 1ns / 1ps

module tb_error_diffusion_halftone;
   import edh_pkg::*;

   localparam int MAX_W        = 1024;
   localparam int SHARE_DIV    = 1 << SHARE_SHIFT;
   localparam int MAX_GAP      = 16;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 2000000;

   typedef enum int {PAT_NOISE, PAT_FLAT, PAT_NEAR_THRESHOLD, PAT_EXTREMES} pattern_type;

   class halftone_scoreboard;
      int unsigned width_reg;
      int unsigned height_reg;
      int          row_err[MAX_W];
      int          right_err;
      int          pend_err[2];
      int          col;
      int          row;
      rsp_type     expected_q[$];
      int          errors;

      function new();
         width_reg  = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         errors     = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         foreach (row_err[i]) row_err[i] = 0;
         right_err   = 0;
         pend_err[0] = 0;
         pend_err[1] = 0;
         col         = 0;
         row         = 0;
      endfunction

      function int clip_err(int v);
         if (v > int'(ERR_MAX)) return int'(ERR_MAX);
         if (v < int'(ERR_MIN)) return int'(ERR_MIN);
         return v;
      endfunction

      function int eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_W) return MAX_W;
         return width_reg;
      endfunction

      function int eff_height();
         return (height_reg == 0) ? 1 : height_reg;
      endfunction

      function void note_config(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_IMAGE_WIDTH) begin
            width_reg = data[WIDTH_REG_W-1:0];
         end else begin
            height_reg = data;
         end
         clear_frame();
      endfunction

      function void note_request(pixel_type pix);
         int      w, h, x, f, d;
         bit      last_col, last_row;
         rsp_type r;
         w = eff_width();
         h = eff_height();
         x = (col >= w) ? w - 1 : col;
         last_col = (x + 1 == w);
         last_row = (row + 1 >= h);
         f = int'(pix) + clip_err(row_err[x] + right_err);
         if (f >= THRESHOLD) begin
            d = f - WHITE_LEVEL;
            r.out_pixel = PIXEL_WHITE;
         end else begin
            d = f;
            r.out_pixel = PIXEL_BLACK;
         end
         if (!last_row) begin
            if (x > 0) begin
               row_err[x-1] = clip_err(pend_err[0] + d * int'(W_DOWN_LEFT) / SHARE_DIV);
            end
            pend_err[0] = clip_err(pend_err[1] + d * int'(W_DOWN) / SHARE_DIV);
            pend_err[1] = last_col ? 0 : clip_err(d * int'(W_DOWN_RIGHT) / SHARE_DIV);
         end
         right_err = last_col ? 0 : clip_err(d * int'(W_RIGHT) / SHARE_DIV);
         r.end_of_row   = last_col;
         r.end_of_frame = last_col && last_row;
         expected_q.push_back(r);
         if (last_col) begin
            if (last_row) begin
               clear_frame();
            end else begin
               row_err[x]  = pend_err[0];
               pend_err[0] = 0;
               pend_err[1] = 0;
               col         = 0;
               row++;
            end
         end else begin
            col = x + 1;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: out_pixel %0d end_of_row %0b end_of_frame %0b",
                     $time, got.out_pixel, got.end_of_row, got.end_of_frame);
            return;
         end
         want = expected_q.pop_front();
         if (got.out_pixel !== want.out_pixel) begin
            errors++;
            $display("%0t: out_pixel expected %0d actual %0d",
                     $time, want.out_pixel, got.out_pixel);
         end
         if (got.end_of_row !== want.end_of_row) begin
            errors++;
            $display("%0t: end_of_row expected %0b actual %0b",
                     $time, want.end_of_row, got.end_of_row);
         end
         if (got.end_of_frame !== want.end_of_frame) begin
            errors++;
            $display("%0t: end_of_frame expected %0b actual %0b",
                     $time, want.end_of_frame, got.end_of_frame);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   pixel_type             req_pixel;
   logic                  rsp_valid;
   logic                  rsp_ready;
   pixel_type             rsp_out_pixel;
   logic                  rsp_end_of_row;
   logic                  rsp_end_of_frame;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   halftone_scoreboard sb;
   bit                 gaps_on;
   bit                 stalls_on;
   int                 holds_wanted = 0;
   int                 holds_done   = 0;
   int                 cycle_count  = 0;

   error_diffusion_halftone #(.MAX_WIDTH(MAX_W)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_pixel    (rsp_out_pixel),
      .rsp_end_of_row   (rsp_end_of_row),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic pixel_type pick_pixel(pattern_type pat, int level);
      case (pat)
         PAT_FLAT:           return pixel_type'(level);
         PAT_NEAR_THRESHOLD: return pixel_type'($urandom_range(THRESHOLD - 8, THRESHOLD + 8));
         PAT_EXTREMES:       return $urandom_range(0, 1) ? PIXEL_WHITE : PIXEL_BLACK;
         default:            return pixel_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixels(input pixel_type pix[$]);
      int gap;
      foreach (pix[i]) begin
         gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_pixel <= pix[i];
         do @(posedge clock); while (req_ready !== 1'b1);
         sb.note_request(pix[i]);
      end
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.note_config(idx, data);
   endtask

   task automatic configure(input bit set_w, input logic [CSR_DATA_W-1:0] w_data,
                            input bit set_h, input logic [CSR_DATA_W-1:0] h_data);
      wait_idle();
      if (set_w) write_csr(CSR_IMAGE_WIDTH, w_data);
      if (set_h) write_csr(CSR_IMAGE_HEIGHT, h_data);
      if (set_w || set_h) csr_we <= 1'b0;
   endtask

   initial begin : receiver
      int      stall;
      rsp_type got;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (holds_done != holds_wanted) begin
            stall = LONG_HOLD;
            holds_done++;
         end else begin
            stall = stalls_on ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.out_pixel    = rsp_out_pixel;
         got.end_of_row   = rsp_end_of_row;
         got.end_of_frame = rsp_end_of_frame;
         sb.check_response(got);
      end
   end

   initial begin : stimulus
      pixel_type             batch[$];
      int                    phase, random_sent, count, frame, w, h, sel, level;
      pattern_type           pat;
      logic [CSR_DATA_W-1:0] w_data, h_data;
      bit                    set_w, set_h;

      sb        = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_pixel = '0;
      csr_we    = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset geometry, threshold edges
      send_pixels('{8'd0, 8'd255, 8'd128, 8'd127});
      // zero width and height act as a 1x1 frame
      configure(1'b1, 16'hF800, 1'b1, 16'h0000);
      send_pixels('{8'd128, 8'd127, 8'd255});
      configure(1'b1, 16'd3, 1'b1, 16'd2);
      send_pixels('{8'd255, 8'd0, 8'd128, 8'd127, 8'd200, 8'd60});
      configure(1'b1, 16'd2, 1'b1, 16'd3);
      send_pixels('{8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100});
      configure(1'b1, 16'd1, 1'b0, 16'd0);
      send_pixels('{8'd90, 8'd90, 8'd90, 8'd90});

      phase       = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         phase++;
         sel = $urandom_range(0, 9);
         w = (sel == 0) ? 0 : (sel == 1) ? 1 : (sel == 2) ? 2 :
             (sel < 8) ? $urandom_range(3, 20) : $urandom_range(21, 200);
         sel = $urandom_range(0, 9);
         h = (sel == 0) ? 0 : (sel == 1) ? 1 : (sel == 2) ? 65535 : $urandom_range(2, 8);
         w_data = {5'($urandom_range(0, 31)), 11'(w)};
         h_data = 16'(h);
         sel    = $urandom_range(0, 3);
         set_w  = (sel != 1);
         set_h  = (sel != 0);
         if (phase == 2) begin
            // oversized width acts as the full line store
            w_data = {5'($urandom_range(0, 31)), 11'h7FF};
            h_data = 16'd2;
            set_w  = 1'b1;
            set_h  = 1'b1;
         end
         configure(set_w, w_data, set_h, h_data);
         frame = sb.eff_width() * sb.eff_height();
         if ($urandom_range(0, 4) == 0) begin
            count = $urandom_range(1, frame);
         end else begin
            count = frame * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, sb.eff_width());
         end
         if (count > 300) count = $urandom_range(100, 300);

         sel       = $urandom_range(0, 4);
         gaps_on   = (sel != 0) && (sel != 2);
         stalls_on = (sel != 0) && (sel != 1);
         if (phase == 1) begin
            // back-pressure: sender streams while the receiver sits on its ready
            gaps_on = 1'b0;
            holds_wanted++;
            if (count < 80) count = 80;
         end

         pat   = pattern_type'($urandom_range(0, 3));
         level = $urandom_range(0, 255);
         batch.delete();
         repeat (count) batch.push_back(pick_pixel(pat, level));
         send_pixels(batch);
         random_sent += count;
      end

      wait_idle();
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* files.f */
src/edh_pkg.sv
src/edh_out_fifo.sv
src/error_diffusion_halftone.sv
verif/tb_error_diffusion_halftone.sv
